>>> rtl/core/priority_sum_tree_defines.svh
// Assertion macros for the priority sum tree top module.
`ifndef PRIORITY_SUM_TREE_DEFINES_SVH
`define PRIORITY_SUM_TREE_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define PST_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define PST_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pst_pkg.sv
// Types and constants shared by the priority sum tree modules.
package pst_pkg;

   localparam int IDX_W  = 10;
   localparam int PRIO_W = 24;
   localparam int SUM_W  = 34;
   localparam int SIZE_W = 11;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_WALK,
      ST_SMP_WALK,
      ST_SMP_CHECK,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_ROOT_LEFT,
      RD_SIBLING,
      RD_PARENT_SIBLING,
      RD_NEXT_LEFT
   } rd_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       clear_step;
      logic       upd_leaf;
      logic       upd_walk;
      logic       smp_walk;
      logic       smp_check;
      logic       div_step;
      logic       div_last;
      logic       load_out;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic clear_last;
      logic parent_is_root;
      logic child_is_leaf;
      logic div_needed;
   } sts_type;

endpackage

>>> rtl/core/pst_channels.sv
// Valid/ready channel interfaces for request and response items.
interface pst_req_if;
   import pst_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [IDX_W-1:0]    leaf_index;
   logic [PRIO_W-1:0]   priority_req;
   logic [SUM_W-1:0]    seed;
   logic [SIZE_W-1:0]   current_size;

   modport source (
      output valid, opcode, leaf_index, priority_req, seed, current_size,
      input  ready
   );
   modport sink (
      input  valid, opcode, leaf_index, priority_req, seed, current_size,
      output ready
   );
endinterface

interface pst_rsp_if;
   import pst_pkg::*;

   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    sampled_index;
   logic [SUM_W-1:0]    total_sum;

   modport source (
      output valid, sampled_index, total_sum,
      input  ready
   );
   modport sink (
      input  valid, sampled_index, total_sum,
      output ready
   );
endinterface

>>> rtl/core/priority_sum_tree.sv
// Priority sum tree: prioritized sampling over a binary tree of leaf sums.
//
// req_port carries one item per valid/ready handshake: an update (opcode 0)
// writes leaf_index with priority_req, a sample (opcode 1) walks the tree
// with seed and wraps the leaf reached by current_size. rsp_port returns one
// item per request: sampled_index (zero for an update) and the root total.
// The memory does one read per tree level: an update whose leaf_index is
// below LEAVES writes the leaf and walks up to the root, a sample walks down
// to a leaf and checks it, then takes remainder steps (one remainder bit per
// cycle) when the index has to be wrapped; the result is then loaded into
// the output register. One item is in the tree at a time; the next can be
// accepted in the cycle after the result is loaded. A finished result may
// still wait in the output register at that point.
// After reset every entry of the tree memory is swept to zero while
// req_port.ready stays low.
// When the receiver stalls, the result holds in the output register and a
// following item stops at its final step until that register is taken.
`include "priority_sum_tree_defines.svh"

module priority_sum_tree #(
   parameter int LEAVES = 1024
) (
   input  logic     clock,
   input  logic     reset,
   pst_req_if.sink  req_port,
   pst_rsp_if.source rsp_port
);
   import pst_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic       req_ready;
   logic       rsp_valid;
   logic       req_fire;
   logic       out_free;
   logic       rsp_drain;
   logic [5:0] dp_ops;

   pst_controller #(
      .LEAVES (LEAVES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_port.valid),
      .req_opcode (req_port.opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_port.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pst_datapath #(
      .LEAVES (LEAVES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_port.opcode),
      .req_leaf_index    (req_port.leaf_index),
      .req_priority_req  (req_port.priority_req),
      .req_seed          (req_port.seed),
      .req_current_size  (req_port.current_size),
      .rsp_sampled_index (rsp_port.sampled_index),
      .rsp_total_sum     (rsp_port.total_sum)
   );

   assign req_port.ready = req_ready;
   assign rsp_port.valid = rsp_valid;

   assign req_fire  = req_port.valid && req_port.ready;
   assign out_free  = !rsp_port.valid || rsp_port.ready;
   assign rsp_drain = rsp_port.valid && rsp_port.ready && !cmd.load_out;
   assign dp_ops    = {cmd.clear_step, cmd.upd_leaf, cmd.upd_walk, cmd.smp_walk,
                       cmd.smp_check, cmd.div_step};

   `PST_ASSERT_NEXT(a_one_item_in_flight, req_fire, !req_port.ready, "item accepted while busy")
   `PST_ASSERT_SAME(a_no_result_overwrite, cmd.load_out, out_free, "result overwritten")
   `PST_ASSERT_NEXT(a_no_duplicate_result, rsp_drain, !rsp_port.valid, "result repeated")
   `PST_ASSERT_ALWAYS(a_datapath_ops_exclusive, $onehot0(dp_ops), "conflicting datapath commands")

endmodule

>>> rtl/core/pst_datapath.sv
// Sum tree memory, walk registers, remainder unit and output register.
module pst_datapath #(
   parameter int LEAVES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pst_pkg::cmd_type              cmd,
   output pst_pkg::sts_type              sts,
   input  logic                          req_opcode,
   input  logic [pst_pkg::IDX_W-1:0]     req_leaf_index,
   input  logic [pst_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic [pst_pkg::SUM_W-1:0]     req_seed,
   input  logic [pst_pkg::SIZE_W-1:0]    req_current_size,
   output logic [pst_pkg::IDX_W-1:0]     rsp_sampled_index,
   output logic [pst_pkg::SUM_W-1:0]     rsp_total_sum
);
   import pst_pkg::*;

   localparam int IW    = $clog2(LEAVES);
   localparam int PAD   = 1 << IW;
   localparam int NW    = IW + 1;
   localparam int DEPTH = 2 * PAD;

   logic [SUM_W-1:0]  sums_mem [DEPTH];
   logic [SUM_W-1:0]  rdata_ff;

   logic [NW-1:0]     node_ff, node_in;
   logic [SUM_W-1:0]  root_ff, root_in;
   logic [SUM_W-1:0]  cur_ff, cur_in;
   logic [SUM_W-1:0]  seed_ff, seed_in;
   logic [SIZE_W-1:0] csize_ff, csize_in;
   logic              in_range_ff, in_range_in;
   logic [IW-1:0]     dvd_ff, dvd_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]  res_ff, res_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [SUM_W-1:0]  out_sum_ff, out_sum_in;

   logic [NW-1:0]     parent;
   logic [NW-1:0]     next_node;
   logic [NW-1:0]     mem_raddr;
   logic [NW-1:0]     mem_waddr;
   logic [SUM_W-1:0]  mem_wdata;
   logic              mem_we;
   logic              left_ge;
   logic [SUM_W-1:0]  pair_sum;
   logic [IW-1:0]     leaf_slot;
   logic              wrap;
   logic              size_zero;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W-1:0] rem_next;

   assign parent    = {1'b0, node_ff[NW-1:1]};
   assign left_ge   = rdata_ff >= seed_ff;
   assign next_node = {node_ff[NW-2:0], ~left_ge};
   assign pair_sum  = rdata_ff + cur_ff;
   assign leaf_slot = node_ff[IW-1:0];
   assign wrap      = 32'(leaf_slot) > 32'(csize_ff);
   assign size_zero = csize_ff == '0;

   // one restoring step of the remainder
   assign trial    = {rem_ff, dvd_ff[IW-1]};
   assign rem_next = (trial >= {1'b0, csize_ff}) ? SIZE_W'(trial - {1'b0, csize_ff})
                                                 : trial[SIZE_W-1:0];

   assign sts.in_range       = in_range_ff;
   assign sts.clear_last     = &node_ff;
   assign sts.parent_is_root = node_ff[NW-1:1] == (NW-1)'(1);
   assign sts.child_is_leaf  = node_ff[IW-1];
   assign sts.div_needed     = wrap && !size_zero;

   always_comb begin
      case (cmd.rd_sel)
         RD_ROOT_LEFT:      mem_raddr = NW'(2);
         RD_SIBLING:        mem_raddr = {node_ff[NW-1:1], ~node_ff[0]};
         RD_PARENT_SIBLING: mem_raddr = parent ^ NW'(1);
         RD_NEXT_LEFT:      mem_raddr = {next_node[NW-2:0], 1'b0};
         default:           mem_raddr = NW'(2);
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = node_ff;
      mem_wdata = '0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.upd_leaf) begin
         mem_we    = 1'b1;
         mem_wdata = cur_ff;
      end else if (cmd.upd_walk) begin
         mem_we    = 1'b1;
         mem_waddr = parent;
         mem_wdata = pair_sum;
      end
   end

   always_comb begin
      node_in     = node_ff;
      root_in     = root_ff;
      cur_in      = cur_ff;
      seed_in     = seed_ff;
      csize_in    = csize_ff;
      in_range_in = in_range_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      res_in      = res_ff;
      out_idx_in  = out_idx_ff;
      out_sum_in  = out_sum_ff;

      if (cmd.clear_step) begin
         node_in = node_ff + 1'b1;
      end
      if (cmd.load_req) begin
         node_in     = (req_opcode == OP_SAMPLE) ? NW'(1)
                                                 : NW'(PAD + int'(req_leaf_index));
         cur_in      = SUM_W'(req_priority_req);
         seed_in     = req_seed;
         csize_in    = req_current_size;
         in_range_in = 32'(req_leaf_index) < LEAVES;
         res_in      = '0;
      end
      if (cmd.upd_walk) begin
         node_in = parent;
         cur_in  = pair_sum;
         if (sts.parent_is_root) begin
            root_in = pair_sum;
         end
      end
      if (cmd.smp_walk) begin
         node_in = next_node;
         if (!left_ge) begin
            seed_in = seed_ff - rdata_ff;
         end
      end
      if (cmd.smp_check) begin
         res_in = wrap ? '0 : IDX_W'(leaf_slot);
         rem_in = '0;
         dvd_in = leaf_slot;
      end
      if (cmd.div_step) begin
         rem_in = rem_next;
         dvd_in = dvd_ff << 1;
         if (cmd.div_last) begin
            res_in = IDX_W'(rem_next);
         end
      end
      if (cmd.load_out) begin
         out_idx_in = res_ff;
         out_sum_in = root_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= sums_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
         root_ff <= '0;
      end else begin
         node_ff <= node_in;
         root_ff <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      seed_ff     <= seed_in;
      csize_ff    <= csize_in;
      in_range_ff <= in_range_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      out_idx_ff  <= out_idx_in;
      out_sum_ff  <= out_sum_in;
   end

   assign rsp_sampled_index = out_idx_ff;
   assign rsp_total_sum     = out_sum_ff;

endmodule

>>> rtl/core/pst_controller.sv
// Sequencer for clearing, update walks, sample walks and the remainder steps.
module pst_controller #(
   parameter int LEAVES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_opcode,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  pst_pkg::sts_type sts,
   output pst_pkg::cmd_type cmd
);
   import pst_pkg::*;

   localparam int IW = $clog2(LEAVES);
   localparam int CW = $clog2(IW + 1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = cmd_type'('0);
      cmd.rd_sel = RD_ROOT_LEFT;
      req_ready  = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = (req_opcode == OP_SAMPLE) ? ST_SMP_WALK : ST_UPD_LEAF;
            end
         end
         ST_UPD_LEAF: begin
            if (sts.in_range) begin
               cmd.upd_leaf = 1'b1;
               cmd.rd_sel   = RD_SIBLING;
               state_in     = ST_UPD_WALK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UPD_WALK: begin
            cmd.upd_walk = 1'b1;
            cmd.rd_sel   = RD_PARENT_SIBLING;
            if (sts.parent_is_root) begin
               state_in = ST_DONE;
            end
         end
         ST_SMP_WALK: begin
            cmd.smp_walk = 1'b1;
            cmd.rd_sel   = RD_NEXT_LEFT;
            if (sts.child_is_leaf) begin
               state_in = ST_SMP_CHECK;
            end
         end
         ST_SMP_CHECK: begin
            cmd.smp_check = 1'b1;
            cnt_in        = '0;
            state_in      = sts.div_needed ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(IW - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
